// File: hw/rtl/cwaf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwaf_pkg
// Shared widths, defaults, register indexes and the control/status types of
// the channel window averager.
// ----------------------------------------------------------------------------
package cwaf_pkg;

	localparam int CHAN_W        = 2;
	localparam int READING_W     = 20;
	localparam int BOUND_W       = 19;
	localparam int FAULT_W       = 3;
	localparam int CFG_INDEX_W   = 1;

	localparam int CHANNELS_DEF  = 4;
	localparam int WINDOW_DEF    = 8;

	localparam logic [FAULT_W-1:0] FAULT_LIMIT = 3'd5;

	localparam logic [BOUND_W-1:0] MAX_ABS_RESET = 19'd21952;
	localparam logic [BOUND_W-1:0] MIN_ABS_RESET = 19'd0;

	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ABS = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MIN_ABS = 1'b1;

	typedef struct packed {
		logic capture;
		logic update;
		logic div_start;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic ch_ok;
		logic report;
		logic fault_hit;
		logic div_done;
		logic out_free;
	} status_t;

endpackage

// File: hw/rtl/cwaf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwaf_ctrl
// Sequencer: takes one transfer and updates the channel state; a reporting item
// then runs the divider, unless a fault skips it, and loads the output register.
// ----------------------------------------------------------------------------
module cwaf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  cwaf_pkg::status_t   status,
	output cwaf_pkg::cmd_t      cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_START,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && status.ch_ok)
						state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					priority if (!status.report)
						state_q <= ST_IDLE;
					else if (status.fault_hit)
						state_q <= ST_DONE;
					else
						state_q <= ST_START;
				end
				ST_START: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (status.div_done)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (status.out_free)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd           = '0;
		cmd.capture   = (state_q == ST_IDLE) && in_valid;
		cmd.update    = (state_q == ST_UPDATE);
		cmd.div_start = (state_q == ST_START);
		cmd.out_load  = (state_q == ST_DONE) && status.out_free;
	end

endmodule

// File: hw/rtl/cwaf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwaf_div
// Unsigned restoring divider, one quotient bit per cycle. A zero divisor
// gives a zero quotient.
// ----------------------------------------------------------------------------
module cwaf_div #(
	parameter int DVD_W = 23,
	parameter int DVS_W = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int STEP_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic [DVD_W-1:0]  quo_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVS_W-1:0]  dvs_q;
	logic              zero_q;
	logic [DVS_W:0]    trial;
	logic              ge;
	logic [DVS_W:0]    diff;

	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign ge    = (trial >= {1'b0, dvs_q});
	assign diff  = trial - {1'b0, dvs_q};
	assign done  = busy_q && (step_q == STEP_W'(DVD_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			if (done)
				busy_q <= 1'b0;
			step_q <= step_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q  <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
			zero_q <= (divisor == '0);
		end else if (busy_q) begin
			if (DVD_W > 1)
				quo_q <= {quo_q[DVD_W-2:0], ge};
			else
				quo_q <= DVD_W'(ge);
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
		end
	end

	assign quotient = zero_q ? '0 : quo_q;

endmodule

// File: hw/rtl/cwaf_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwaf_dp
// Datapath: bound registers, sample store, per-channel sum, pointer, fill
// and fault state, the divider and the output register.
// ----------------------------------------------------------------------------
module cwaf_dp #(
	parameter int CHANNELS = cwaf_pkg::CHANNELS_DEF,
	parameter int WINDOW   = cwaf_pkg::WINDOW_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [cwaf_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [cwaf_pkg::BOUND_W-1:0]          cfg_data,
	input  logic [cwaf_pkg::CHAN_W-1:0]           in_channel,
	input  logic signed [cwaf_pkg::READING_W-1:0] in_reading,
	input  logic                                  in_report,
	input  cwaf_pkg::cmd_t                        cmd,
	output cwaf_pkg::status_t                     status,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [cwaf_pkg::CHAN_W-1:0]           out_channel,
	output logic signed [cwaf_pkg::READING_W-1:0] out_average,
	output logic                                  out_invalid
);

	localparam int RW    = cwaf_pkg::READING_W;
	localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W = $clog2(WINDOW + 1);
	localparam int SUM_W = RW + $clog2(WINDOW);
	localparam int MEM_D = CHANNELS * (2 ** PTR_W);

	logic [cwaf_pkg::BOUND_W-1:0] max_abs_q;
	logic [cwaf_pkg::BOUND_W-1:0] min_abs_q;

	logic signed [RW-1:0] mem [MEM_D];
	logic signed [RW-1:0] rd_data_q;

	logic signed [SUM_W-1:0]   sum_q   [CHANNELS];
	logic [PTR_W-1:0]          ptr_q   [CHANNELS];
	logic                      full_q  [CHANNELS];
	logic [cwaf_pkg::FAULT_W-1:0] fault_q [CHANNELS];

	logic [cwaf_pkg::CHAN_W-1:0] chan_q;
	logic [CH_W-1:0]             ch_q;
	logic signed [RW-1:0]        rd_q;
	logic                        report_q;
	logic                        inv_q;
	logic                        neg_q;

	logic [CH_W-1:0]              in_ch;
	logic [RW-1:0]                mag;
	logic                         in_bounds;
	logic signed [RW-1:0]         old_sample;
	logic signed [SUM_W-1:0]      sum_upd;
	logic                         ptr_last;
	logic [PTR_W-1:0]             ptr_nx;
	logic [cwaf_pkg::FAULT_W-1:0] fault_nx;
	logic                         fault_hit;
	logic signed [SUM_W-1:0]      sum_cur;
	logic [SUM_W-1:0]             dvd;
	logic [CNT_W-1:0]             dvs;
	logic                         div_done;
	logic [SUM_W-1:0]             quot;
	logic [SUM_W-1:0]             avg_full;
	logic                         out_valid_q;
	logic                         out_free;

	assign in_ch = CH_W'(in_channel);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_abs_q <= cwaf_pkg::MAX_ABS_RESET;
			min_abs_q <= cwaf_pkg::MIN_ABS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cwaf_pkg::CFG_MAX_ABS: max_abs_q <= cfg_data;
				cwaf_pkg::CFG_MIN_ABS: min_abs_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture && status.ch_ok) begin
			chan_q    <= in_channel;
			ch_q      <= in_ch;
			rd_q      <= in_reading;
			report_q  <= in_report;
			rd_data_q <= mem[{in_ch, ptr_q[in_ch]}];
		end
		if (cmd.update && in_bounds)
			mem[{ch_q, ptr_q[ch_q]}] <= rd_q;
	end

	assign mag        = rd_q[RW-1] ? (~rd_q + 1'b1) : rd_q;
	assign in_bounds  = (mag <= {1'b0, max_abs_q}) && (mag >= {1'b0, min_abs_q});
	assign old_sample = full_q[ch_q] ? rd_data_q : '0;
	assign sum_upd    = sum_q[ch_q] - SUM_W'(old_sample) + SUM_W'(rd_q);
	assign ptr_last   = (ptr_q[ch_q] == PTR_W'(WINDOW - 1));
	assign ptr_nx     = ptr_last ? '0 : ptr_q[ch_q] + 1'b1;

	always_comb begin
		if (in_bounds)
			fault_nx = '0;
		else if (fault_q[ch_q] < cwaf_pkg::FAULT_LIMIT)
			fault_nx = fault_q[ch_q] + 1'b1;
		else
			fault_nx = fault_q[ch_q];
	end

	assign fault_hit = report_q && (fault_nx >= cwaf_pkg::FAULT_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				sum_q[i]   <= '0;
				ptr_q[i]   <= '0;
				full_q[i]  <= 1'b0;
				fault_q[i] <= '0;
			end
		end else if (cmd.update) begin
			fault_q[ch_q] <= fault_nx;
			priority if (fault_hit) begin
				sum_q[ch_q]  <= '0;
				ptr_q[ch_q]  <= '0;
				full_q[ch_q] <= 1'b0;
			end else if (in_bounds) begin
				sum_q[ch_q]  <= sum_upd;
				ptr_q[ch_q]  <= ptr_nx;
				full_q[ch_q] <= full_q[ch_q] || ptr_last;
			end
		end
	end

	assign sum_cur = sum_q[ch_q];
	assign dvd     = sum_cur[SUM_W-1] ? (~sum_cur + 1'b1) : sum_cur;
	assign dvs     = full_q[ch_q] ? CNT_W'(WINDOW) : CNT_W'(ptr_q[ch_q]);

	always_ff @(posedge clk) begin
		if (cmd.update)
			inv_q <= fault_hit;
		if (cmd.div_start)
			neg_q <= sum_cur[SUM_W-1];
	end

	cwaf_div #(
		.DVD_W (SUM_W),
		.DVS_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.done     (div_done),
		.quotient (quot)
	);

	assign avg_full = neg_q ? (~quot + 1'b1) : quot;
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_channel <= chan_q;
			out_invalid <= inv_q;
			out_average <= inv_q ? '0 : avg_full[RW-1:0];
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		status           = '0;
		status.ch_ok     = (32'(in_channel) < CHANNELS);
		status.report    = report_q;
		status.fault_hit = fault_hit;
		status.div_done  = div_done;
		status.out_free  = out_free;
	end

endmodule

// File: hw/rtl/channel_window_average_with_fault.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// channel_window_average_with_fault
// Per-channel moving average over a circular sample window, with a fault
// counter that flags a result invalid and clears the channel's window.
// An input transfer is followed by the channel update, the divider start and a
// bit-serial divide with one quotient bit per cycle, then by the output load. An
// invalid result skips the divider, and an item that reports nothing frees the
// input after the channel update. For a reporting item the next input transfer
// is taken once the result sits in the output register.
// Reset is asynchronous and active low; it clears all channel state at once,
// the sample store needs no clearing pass.
// ----------------------------------------------------------------------------
module channel_window_average_with_fault #(
	parameter int CHANNELS = cwaf_pkg::CHANNELS_DEF,
	parameter int WINDOW   = cwaf_pkg::WINDOW_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [cwaf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [cwaf_pkg::BOUND_W-1:0]     cfg_data,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [23:0]                      s_tdata,  // channel, reading, zero pad
	input  logic                             s_tuser,  // report_enable
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [23:0]                      m_tdata,  // out_channel, average, zero pad
	output logic                             m_tuser   // invalid
);

	cwaf_pkg::cmd_t    cmd;
	cwaf_pkg::status_t status;

	logic [cwaf_pkg::CHAN_W-1:0]           out_channel;
	logic signed [cwaf_pkg::READING_W-1:0] out_average;

	cwaf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	cwaf_dp #(
		.CHANNELS (CHANNELS),
		.WINDOW   (WINDOW)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_channel  (s_tdata[1:0]),
		.in_reading  (s_tdata[21:2]),
		.in_report   (s_tuser),
		.cmd         (cmd),
		.status      (status),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_channel (out_channel),
		.out_average (out_average),
		.out_invalid (m_tuser)
	);

	assign m_tdata = {2'b00, out_average, out_channel};

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && status.ch_ok) |=> !s_tready)
		else $error("input taken again before the previous item finished");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid || m_tready))
		else $error("output register loaded over a pending result");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[21:2] == '0))
		else $error("invalid result carries a non-zero average");

	a_div_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		status.div_done |-> !s_tready)
		else $error("divider finished while the block was idle");

endmodule

// File: tb/sv/channel_window_average_with_fault_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// channel_window_average_with_fault_tb
// Self-checking bench for the per-channel window averager with fault
// counter. Readings stream in with random gaps, results drain with random
// back-pressure, and a scoreboard that tracks every channel's window, sum,
// pointer and fault count predicts each reported average. The bounds are
// changed between phases, including the widest, narrowest and crossed
// settings.
// ----------------------------------------------------------------------------
module channel_window_average_with_fault_tb;

	localparam int CHANS          = cwaf_pkg::CHANNELS_DEF;
	localparam int WIN            = cwaf_pkg::WINDOW_DEF;
	localparam int DRAIN_CYCLES   = 64;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int READING_MAX    = 524287;

	typedef struct {
		logic [cwaf_pkg::CHAN_W-1:0]           chan;
		logic signed [cwaf_pkg::READING_W-1:0] avg;
		logic                                  inv;
	} avg_result_t;

	class average_scoreboard;
		logic signed [cwaf_pkg::READING_W-1:0] samples [CHANS][WIN];
		logic signed [24:0]                    sums [CHANS];
		int                                    slot [CHANS];
		bit                                    full [CHANS];
		logic [cwaf_pkg::FAULT_W-1:0]          faults [CHANS];
		int                                    max_bound;
		int                                    min_bound;
		avg_result_t                           pending [$];
		int                                    errors;
		int                                    checked;
		int                                    invalid_seen;

		function new();
			max_bound = int'(cwaf_pkg::MAX_ABS_RESET);
			min_bound = int'(cwaf_pkg::MIN_ABS_RESET);
			errors = 0;
			checked = 0;
			invalid_seen = 0;
			for (int c = 0; c < CHANS; c++) begin
				clear_window(c);
				faults[c] = '0;
			end
		endfunction

		function void clear_window(int c);
			for (int i = 0; i < WIN; i++) begin
				samples[c][i] = '0;
			end
			sums[c] = '0;
			slot[c] = 0;
			full[c] = 1'b0;
		endfunction

		function void write_register(logic [cwaf_pkg::CFG_INDEX_W-1:0] idx, int value);
			if (idx == cwaf_pkg::CFG_MAX_ABS) begin
				max_bound = value & READING_MAX;
			end else begin
				min_bound = value & READING_MAX;
			end
		endfunction

		function void note_transfer(logic [cwaf_pkg::CHAN_W-1:0] ch,
				logic signed [cwaf_pkg::READING_W-1:0] rd, logic rep);
			int mag;
			int cnt;
			int total;
			int quotient;
			avg_result_t r;
			mag = (rd < 0) ? -int'(rd) : int'(rd);
			if (mag <= max_bound && mag >= min_bound) begin
				sums[ch] = sums[ch] - samples[ch][slot[ch]] + rd;
				samples[ch][slot[ch]] = rd;
				slot[ch]++;
				if (slot[ch] >= WIN) begin
					slot[ch] = 0;
					full[ch] = 1'b1;
				end
				faults[ch] = '0;
			end else if (faults[ch] < cwaf_pkg::FAULT_LIMIT) begin
				faults[ch]++;
			end
			cnt = full[ch] ? WIN : slot[ch];
			total = int'(sums[ch]);
			quotient = (cnt > 0) ? total / cnt : 0;
			if (!rep) return;
			r.chan = ch;
			if (faults[ch] >= cwaf_pkg::FAULT_LIMIT) begin
				r.avg = '0;
				r.inv = 1'b1;
				clear_window(ch);
			end else begin
				r.avg = quotient[cwaf_pkg::READING_W-1:0];
				r.inv = 1'b0;
			end
			pending.push_back(r);
		endfunction

		function void check_result(logic [cwaf_pkg::CHAN_W-1:0] ch,
				logic signed [cwaf_pkg::READING_W-1:0] avg, logic inv);
			avg_result_t r;
			if (pending.size() == 0) begin
				$error("result on channel %0d with no average pending", ch);
				errors++;
				return;
			end
			r = pending.pop_front();
			checked++;
			if (inv === 1'b1) invalid_seen++;
			if (ch !== r.chan) begin
				$error("out_channel mismatch: expected %0d, got %0d", r.chan, ch);
				errors++;
			end
			if (avg !== r.avg) begin
				$error("average mismatch: expected %0d, got %0d", r.avg, avg);
				errors++;
			end
			if (inv !== r.inv) begin
				$error("invalid mismatch: expected %0d, got %0d", r.inv, inv);
				errors++;
			end
		endfunction
	endclass

	logic                             clk;
	logic                             arst_n;
	logic                             cfg_we;
	logic [cwaf_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [cwaf_pkg::BOUND_W-1:0]     cfg_data;
	logic                             s_tvalid;
	logic                             s_tready;
	logic [23:0]                      s_tdata;   // channel, reading, zero pad
	logic                             s_tuser;   // report_enable
	logic                             m_tvalid;
	logic                             m_tready;
	logic [23:0]                      m_tdata;   // out_channel, average, zero pad
	logic                             m_tuser;   // invalid

	average_scoreboard sb;
	int  cur_max = int'(cwaf_pkg::MAX_ABS_RESET);
	int  cur_min = int'(cwaf_pkg::MIN_ABS_RESET);
	bit  steady = 1'b0;
	int  stall_left = 0;
	int  idle_cycles = 0;
	int  items_sent = 0;
	int  settings_used = 1;

	channel_window_average_with_fault dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int input_gap();
		int r;
		if (steady) return 0;
		r = $urandom_range(99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int stall_gap();
		if ($urandom_range(99) < 80) return $urandom_range(1, 3);
		return $urandom_range(10, 50);
	endfunction

	function automatic int signed_reading(int mag);
		if (mag > READING_MAX || $urandom_range(1) == 1) return -mag;
		return mag;
	endfunction

	function automatic int fault_reading();
		int pick;
		if (cur_min > cur_max) return int'($urandom_range(0, 1048575)) - 524288;
		pick = $urandom_range(2);
		if (pick == 0 && cur_max < READING_MAX) begin
			return signed_reading($urandom_range(cur_max + 1, READING_MAX + 1));
		end
		if (pick == 1 && cur_min > 0) begin
			return signed_reading($urandom_range(0, cur_min - 1));
		end
		return -(READING_MAX + 1);
	endfunction

	function automatic int good_reading();
		if (cur_min > cur_max) return fault_reading();
		return signed_reading($urandom_range(cur_min, cur_max));
	endfunction

	task automatic hold_input(input int n);
		repeat (n) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
	endtask

	task automatic send_reading(input int ch, input int rd, input bit rep);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, rd[cwaf_pkg::READING_W-1:0], ch[cwaf_pkg::CHAN_W-1:0]};
		s_tuser  <= rep;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_transfer(ch[cwaf_pkg::CHAN_W-1:0], rd[cwaf_pkg::READING_W-1:0], rep);
		items_sent++;
		hold_input(input_gap());
	endtask

	task automatic set_bound(input logic [cwaf_pkg::CFG_INDEX_W-1:0] idx, input int value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[cwaf_pkg::BOUND_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.write_register(idx, value);
		if (idx == cwaf_pkg::CFG_MAX_ABS) begin
			cur_max = value;
		end else begin
			cur_min = value;
		end
	endtask

	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_random(input int count);
		int done;
		int burst;
		int ch;
		done = 0;
		while (done < count) begin
			steady = (done >= count - count / 4);
			if ($urandom_range(99) < 10) begin
				// A run of rejected readings on one channel drives the fault count to its limit.
				ch = $urandom_range(CHANS - 1);
				burst = $urandom_range(5, 7);
				for (int k = 0; k < burst; k++) begin
					send_reading(ch, fault_reading(), (k == burst - 1) ? 1'b1 : 1'($urandom_range(1)));
				end
				done += burst;
			end else begin
				send_reading($urandom_range(CHANS - 1),
					($urandom_range(99) < 78) ? good_reading() : fault_reading(),
					$urandom_range(99) < 70);
				done++;
			end
		end
		steady = 1'b0;
	endtask

	task automatic run_phase(input int max_v, input int min_v, input int count);
		set_bound(cwaf_pkg::CFG_MAX_ABS, max_v);
		set_bound(cwaf_pkg::CFG_MIN_ABS, min_v);
		settings_used++;
		run_random(count);
		settle();
	endtask

	always @(negedge clk) begin
		if (steady) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			m_tready <= 1'b1;
			if ($urandom_range(99) < 30) stall_left = stall_gap();
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				sb.check_result(m_tdata[cwaf_pkg::CHAN_W-1:0],
					$signed(m_tdata[cwaf_pkg::CHAN_W +: cwaf_pkg::READING_W]), m_tuser);
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL channel_window_average_with_fault");
				$finish;
			end
		end
	end

	initial begin
		int hi;
		sb        = new();
		clk       = 1'b0;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		m_tready  = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part under the reset bounds.
		send_reading(3, -524288, 1);
		send_reading(0, 21952, 1);
		send_reading(0, -21952, 1);
		send_reading(0, -3, 1);
		send_reading(0, 21953, 1);
		send_reading(0, 524287, 0);
		send_reading(0, -1, 1);
		send_reading(0, 5, 0);
		send_reading(0, 6, 1);
		send_reading(0, 7, 0);
		send_reading(0, 8, 1);
		send_reading(0, -9, 1);
		send_reading(3, 30000, 0);
		send_reading(3, -30000, 0);
		send_reading(3, 524287, 0);
		send_reading(3, -524288, 0);
		send_reading(3, 22000, 1);
		send_reading(3, 0, 1);
		send_reading(3, -7, 1);
		send_reading(2, -5, 1);
		run_random(150);
		settle();

		run_phase(READING_MAX, 0, 300);
		run_phase(0, 0, 120);
		run_phase(100, 50, 250);
		run_phase(500, 1000, 100);
		run_phase(READING_MAX, READING_MAX, 100);
		run_phase(int'(cwaf_pkg::MAX_ABS_RESET), int'(cwaf_pkg::MIN_ABS_RESET), 250);
		repeat (3) begin
			hi = $urandom_range(0, READING_MAX);
			run_phase(hi, $urandom_range(0, hi), 200);
		end

		if (sb.pending.size() != 0) begin
			$error("%0d expected averages never arrived", sb.pending.size());
			sb.errors++;
		end
		$display("Sent %0d readings over %0d bound settings.", items_sent, settings_used);
		$display("Checked %0d reported averages, %0d of them flagged invalid.",
			sb.checked, sb.invalid_seen);
		if (sb.errors == 0) begin
			$display("PASS channel_window_average_with_fault");
		end else begin
			$display("FAIL channel_window_average_with_fault");
		end
		$finish;
	end

endmodule
